/* rtl/x86_instruction_length_decoder_core_macros.svh */
// Assertion macros used by the checker file.
`ifndef X86_INSTRUCTION_LENGTH_DECODER_CORE_MACROS_SVH
`define X86_INSTRUCTION_LENGTH_DECODER_CORE_MACROS_SVH
// Implication checked at every rising clock edge outside reset.
`define XILD_ASSERT_IMPLY(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);
// Implication whose consequent is checked in the next cycle.
`define XILD_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);
`endif

/* rtl/xild_pkg.sv */
// ----------------------------------------------------------------------------
// xild_pkg
// Constants, phase codes and opcode tables of the x86 length decoder.
// ----------------------------------------------------------------------------
package xild_pkg;

   localparam int MaxInsnBytesDefault = 32;
   localparam int PositionBitsDefault = 32;

   // Decode phases.
   typedef enum logic [3:0] {
      PH_PREFIX, PH_OPCODE, PH_VEXHDR, PH_VEXOP, PH_ESC0F, PH_OP3, PH_MODRM, PH_SIB, PH_TRAIL
   } phase_type;

   // Result status codes.
   localparam logic [1:0] ST_OK        = 2'd0;
   localparam logic [1:0] ST_TRUNCATED = 2'd1;
   localparam logic [1:0] ST_TOO_LONG  = 2'd2;

   // Zero count kinds.
   localparam logic [1:0] KIND_NONE  = 2'd0;
   localparam logic [1:0] KIND_LZCNT = 2'd1;
   localparam logic [1:0] KIND_TZCNT = 2'd2;

   // Immediate size codes.
   localparam logic [2:0] IMM_NONE = 3'd0;
   localparam logic [2:0] IMM_8    = 3'd1;
   localparam logic [2:0] IMM_16   = 3'd2;
   localparam logic [2:0] IMM_Z    = 3'd3;
   localparam logic [2:0] IMM_V    = 3'd4;
   localparam logic [2:0] IMM_MOFF = 3'd5;
   localparam logic [2:0] IMM_ENT  = 3'd6;
   localparam logic [2:0] IMM_GRP3 = 3'd7;

   // Byte values with a meaning of their own.
   localparam logic [7:0] OP_OPSIZE = 8'h66;
   localparam logic [7:0] OP_REP    = 8'hF3;
   localparam logic [7:0] OP_ESC    = 8'h0F;
   localparam logic [7:0] OP_VEX2   = 8'hC5;
   localparam logic [7:0] OP_VEX3   = 8'hC4;
   localparam logic [7:0] OP_EVEX   = 8'h62;
   localparam logic [7:0] OP_MAP38  = 8'h38;
   localparam logic [7:0] OP_MAP3A  = 8'h3A;
   localparam logic [7:0] OP_LZCNT  = 8'hBD;
   localparam logic [7:0] OP_TZCNT  = 8'hBC;
   localparam logic [7:0] OP_VZERO  = 8'h77;

   function automatic logic is_legacy_prefix(input logic [7:0] b);
      return (b inside {8'h66, 8'h67, 8'hF0, 8'hF2, 8'hF3, 8'h2E, 8'h36, 8'h3E, 8'h26,
                        8'h64, 8'h65});
   endfunction

   function automatic logic has_modrm_one(input logic [7:0] op);
      if (op < 8'h40) return (op[2] == 1'b0);
      if (op inside {8'h63, 8'h69, 8'h6B}) return 1'b1;
      if (op inside {[8'h80:8'h8F]}) return (op != 8'h82);
      if (op inside {8'hC0, 8'hC1, 8'hC6, 8'hC7, [8'hD0:8'hD3], [8'hD8:8'hDF]}) return 1'b1;
      return (op inside {8'hF6, 8'hF7, 8'hFE, 8'hFF});
   endfunction

   function automatic logic [2:0] imm_code_one(input logic [7:0] op);
      if (op < 8'h40 && op[2:0] == 3'd4) return IMM_8;
      if (op < 8'h40 && op[2:0] == 3'd5) return IMM_Z;
      if (op inside {8'h68, 8'h69, 8'h81, 8'hA9, 8'hC7, 8'hE8, 8'hE9}) return IMM_Z;
      if (op inside {8'h6A, 8'h6B, 8'h80, 8'h83, 8'hA8, [8'h70:8'h7F]}) return IMM_8;
      if (op inside {[8'hA0:8'hA3]}) return IMM_MOFF;
      if (op inside {[8'hB0:8'hB7]}) return IMM_8;
      if (op inside {[8'hB8:8'hBF]}) return IMM_V;
      if (op inside {8'hC0, 8'hC1, 8'hC6, 8'hCD, 8'hEB, [8'hE0:8'hE7]}) return IMM_8;
      if (op inside {8'hC2, 8'hCA}) return IMM_16;
      if (op == 8'hC8) return IMM_ENT;
      return IMM_NONE;
   endfunction

   function automatic logic has_modrm_0f(input logic [7:0] op);
      if (op inside {[8'h05:8'h09], 8'h0B, 8'h0E, [8'h30:8'h35], 8'h37, 8'h77}) return 1'b0;
      if (op inside {[8'h80:8'h8F], 8'hA0, 8'hA1, 8'hA2, 8'hA8, 8'hA9, 8'hAA}) return 1'b0;
      if (op inside {[8'hC8:8'hCF]}) return 1'b0;
      return 1'b1;
   endfunction

   function automatic logic [2:0] imm_code_0f(input logic [7:0] op);
      if (op inside {[8'h70:8'h73], 8'hA4, 8'hAC, 8'hBA, 8'hC2, 8'hC4, 8'hC5, 8'hC6})
         return IMM_8;
      if (op inside {[8'h80:8'h8F]}) return IMM_Z;
      return IMM_NONE;
   endfunction

   // Immediate byte count for a size code under the held operand size flags.
   function automatic logic [3:0] imm_size(input logic [2:0] code, input logic osz,
                                           input logic rexw);
      case (code)
         IMM_8:    return 4'd1;
         IMM_16:   return 4'd2;
         IMM_Z:    return osz ? 4'd2 : 4'd4;
         IMM_V:    return rexw ? 4'd8 : (osz ? 4'd2 : 4'd4);
         IMM_MOFF: return 4'd8;
         IMM_ENT:  return 4'd3;
         default:  return 4'd0;
      endcase
   endfunction

endpackage

/* rtl/x86_instruction_length_decoder_core.sv */
// ----------------------------------------------------------------------------
// x86_instruction_length_decoder_core
// Finds x86-64 instruction boundaries in a byte stream, one byte per cycle when not stalled.
// ----------------------------------------------------------------------------
// Usage: code bytes enter on the req_ channel, one per transaction, with
// req_tlast set on the last byte of a region. For each instruction boundary,
// truncated instruction or over-long instruction, one transaction leaves on
// the rsp_ channel; bytes that do not end an instruction give nothing.
// A result is shown in rsp_ the cycle after the byte that ends the instruction
// is accepted. One byte per cycle is taken while no result is stalled; the
// decode state is updated combinationally from each accepted byte.
// Reset (synchronous, active high) restarts decoding in the prefix phase at
// region position zero and empties the result register.
// When the receiver stalls, the result register holds its transaction and
// req_tready is low while that result waits, so no byte is taken until the
// receiver accepts it; a result accepted in the same cycle frees the input.
// rsp_tdata: insn_start, insn_length, zero_count_kind, rep_prefix_offset;
// rsp_tuser: status.
// ----------------------------------------------------------------------------
module x86_instruction_length_decoder_core #(
   parameter int MAX_INSN_BYTES = xild_pkg::MaxInsnBytesDefault,
   parameter int POSITION_BITS  = xild_pkg::PositionBitsDefault
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,   // code_byte
   input  logic        req_tlast,   // region_end
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [47:0] rsp_tdata,   // insn_start[31:0], insn_length[37:32],
                                    // zero_count_kind[39:38], rep_prefix_offset[44:40]
   output logic [1:0]  rsp_tuser    // status
);
   import xild_pkg::*;

   localparam int PW = POSITION_BITS;

   phase_type        phase_ff, phase_in;
   logic [5:0]       count_ff, count_in;
   logic             osz_ff, osz_in, rexw_ff, rexw_in, rep_ff, rep_in;
   logic [4:0]       reppos_ff, reppos_in;
   logic [7:0]       op_ff, op_in, modrm_ff, modrm_in;
   logic [1:0]       map_ff, map_in, kind_ff, kind_in;
   logic [3:0]       trail_ff, trail_in;
   logic [2:0]       pimm_ff, pimm_in;
   logic [PW-1:0]    pos_ff, pos_in;

   logic             rv_ff;
   logic [47:0]      rdata_ff, rdata_in;
   logic [1:0]       ruser_ff, ruser_in;

   logic             take, emit, done, clr;
   logic [7:0]       b;
   logic [6:0]       newcount;
   logic [PW-1:0]    start;
   logic [1:0]       st;
   logic [5:0]       elen;
   logic [4:0]       eoff;
   logic [1:0]       ekind;
   logic [3:0]       disp, n_after;
   logic [2:0]       code;

   // Emit only into a free or draining result register.
   assign req_tready = !rv_ff || rsp_tready;
   assign take       = req_tvalid && req_tready;
   assign b          = req_tdata;
   assign newcount   = {1'b0, count_ff} + 7'd1;
   assign start      = pos_ff - PW'(count_ff);

   // Per-byte decode step.
   always_comb begin
      phase_in = phase_ff; count_in = count_ff; osz_in = osz_ff; rexw_in = rexw_ff;
      rep_in = rep_ff; reppos_in = reppos_ff; op_in = op_ff; modrm_in = modrm_ff;
      map_in = map_ff; kind_in = kind_ff; trail_in = trail_ff; pimm_in = pimm_ff;
      done = 1'b0; n_after = 4'd0; disp = 4'd0; code = IMM_NONE;
      clr = 1'b0; emit = 1'b0; st = ST_OK; elen = 6'd0; eoff = 5'd0;
      if (newcount > 7'(MAX_INSN_BYTES)) begin
         emit = 1'b1; st = ST_TOO_LONG; clr = 1'b1;
      end else begin
         count_in = newcount[5:0];
         case (phase_ff)
            PH_PREFIX, PH_OPCODE: begin
               if (phase_ff == PH_PREFIX && is_legacy_prefix(b)) begin
                  if (b == OP_OPSIZE) osz_in = 1'b1;
                  if (b == OP_REP) begin
                     rep_in = 1'b1;
                     reppos_in = (newcount[5:0] - 6'd1 > 6'd31) ? 5'd31 :
                                 5'(newcount[5:0] - 6'd1);
                  end
               end else if (phase_ff == PH_PREFIX && b[7:4] == 4'h4) begin
                  rexw_in = b[3]; phase_in = PH_OPCODE;
               end else begin
                  op_in = b;
                  if (b == OP_VEX2) begin
                     map_in = 2'd1; trail_in = 4'd1; phase_in = PH_VEXHDR;
                  end else if (b == OP_VEX3) begin
                     map_in = 2'd0; trail_in = 4'd2; phase_in = PH_VEXHDR;
                  end else if (b == OP_EVEX) begin
                     map_in = 2'd0; trail_in = 4'd3; phase_in = PH_VEXHDR;
                  end else if (b == OP_ESC) begin
                     phase_in = PH_ESC0F;
                  end else if (has_modrm_one(b)) begin
                     pimm_in = (b == 8'hF6 || b == 8'hF7) ? IMM_GRP3 : imm_code_one(b);
                     phase_in = PH_MODRM;
                  end else begin
                     n_after = imm_size(imm_code_one(b), osz_ff, rexw_ff); done = 1'b1;
                  end
               end
            end
            PH_VEXHDR: begin
               if (op_ff == OP_VEX3 && trail_ff == 4'd2)
                  map_in = (b[4:0] <= 5'd3) ? b[1:0] : 2'd0;
               else if (op_ff == OP_EVEX && trail_ff == 4'd3)
                  map_in = b[1:0];
               trail_in = trail_ff - 4'd1;
               if (trail_in == 4'd0) phase_in = PH_VEXOP;
            end
            PH_VEXOP: begin
               code = (map_ff == 2'd3 || (map_ff == 2'd1 && imm_code_0f(b) == IMM_8)) ?
                      IMM_8 : IMM_NONE;
               op_in = b;
               if (op_ff != OP_EVEX && map_ff == 2'd1 && b == OP_VZERO) begin
                  n_after = {3'd0, code[0]}; done = 1'b1;
               end else begin
                  pimm_in = code; phase_in = PH_MODRM;
               end
            end
            PH_ESC0F: begin
               op_in = b;
               if (b == OP_MAP38) begin
                  pimm_in = IMM_NONE; phase_in = PH_OP3;
               end else if (b == OP_MAP3A) begin
                  pimm_in = IMM_8; phase_in = PH_OP3;
               end else if (b == OP_ESC) begin
                  pimm_in = IMM_8; phase_in = PH_MODRM;
               end else begin
                  if (rep_ff && b == OP_LZCNT) kind_in = KIND_LZCNT;
                  if (rep_ff && b == OP_TZCNT) kind_in = KIND_TZCNT;
                  if (has_modrm_0f(b)) begin
                     pimm_in = imm_code_0f(b); phase_in = PH_MODRM;
                  end else begin
                     n_after = imm_size(imm_code_0f(b), osz_ff, rexw_ff); done = 1'b1;
                  end
               end
            end
            PH_OP3: phase_in = PH_MODRM;
            PH_MODRM: begin
               modrm_in = b;
               code = pimm_ff;
               if (code == IMM_GRP3) begin
                  code = (b[5:4] == 2'b00) ? ((op_ff == 8'hF7) ? IMM_Z : IMM_8) : IMM_NONE;
                  pimm_in = code;
               end
               if (b[7:6] == 2'd3) begin
                  n_after = imm_size(code, osz_ff, rexw_ff); done = 1'b1;
               end else if (b[2:0] == 3'd4) begin
                  phase_in = PH_SIB;
               end else begin
                  disp = ((b[7:6] == 2'd0 && b[2:0] == 3'd5) || b[7:6] == 2'd2) ? 4'd4 :
                         (b[7:6] == 2'd1 ? 4'd1 : 4'd0);
                  n_after = disp + imm_size(code, osz_ff, rexw_ff); done = 1'b1;
               end
            end
            PH_SIB: begin
               disp = ((modrm_ff[7:6] == 2'd0 && b[2:0] == 3'd5) || modrm_ff[7:6] == 2'd2) ?
                      4'd4 : (modrm_ff[7:6] == 2'd1 ? 4'd1 : 4'd0);
               n_after = disp + imm_size(pimm_ff, osz_ff, rexw_ff); done = 1'b1;
            end
            PH_TRAIL: begin
               trail_in = trail_ff - 4'd1;
               if (trail_in == 4'd0) begin
                  emit = 1'b1; elen = newcount[5:0];
                  eoff = (kind_ff != KIND_NONE) ? reppos_ff : 5'd0; clr = 1'b1;
               end
            end
            default: clr = 1'b1;
         endcase
         // Finish now or walk the trailing bytes.
         if (done) begin
            if (n_after == 4'd0) begin
               emit = 1'b1; elen = newcount[5:0];
               eoff = (kind_in != KIND_NONE) ? reppos_in : 5'd0; clr = 1'b1;
            end else begin
               trail_in = n_after; phase_in = PH_TRAIL;
            end
         end
         if (!emit && req_tlast) begin
            emit = 1'b1; st = ST_TRUNCATED; clr = 1'b1;
         end
      end
      // The kind is taken before the instruction state is cleared.
      ekind = (emit && st == ST_OK) ? kind_in : KIND_NONE;
      if (emit && st != ST_OK) begin
         elen = 6'd0; eoff = 5'd0;
      end
      if (clr || req_tlast) begin
         phase_in = PH_PREFIX; count_in = 6'd0; osz_in = 1'b0; rexw_in = 1'b0;
         rep_in = 1'b0; reppos_in = 5'd0; op_in = 8'd0; modrm_in = 8'd0; map_in = 2'd0;
         trail_in = 4'd0; pimm_in = IMM_NONE; kind_in = KIND_NONE;
      end
      pos_in   = req_tlast ? '0 : pos_ff + PW'(1);
      rdata_in = {3'd0, eoff, ekind, elen, 32'(start)};
      ruser_in = st;
   end

   // Decode state and result register.
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_PREFIX; count_ff <= '0; osz_ff <= 1'b0; rexw_ff <= 1'b0;
         rep_ff <= 1'b0; reppos_ff <= '0; op_ff <= '0; modrm_ff <= '0; map_ff <= '0;
         kind_ff <= KIND_NONE; trail_ff <= '0; pimm_ff <= IMM_NONE; pos_ff <= '0;
         rv_ff <= 1'b0;
      end else begin
         if (take) begin
            phase_ff <= phase_in; count_ff <= count_in; osz_ff <= osz_in;
            rexw_ff <= rexw_in; rep_ff <= rep_in; reppos_ff <= reppos_in; op_ff <= op_in;
            modrm_ff <= modrm_in; map_ff <= map_in; kind_ff <= kind_in;
            trail_ff <= trail_in; pimm_ff <= pimm_in; pos_ff <= pos_in;
         end
         if (take && emit)    rv_ff <= 1'b1;
         else if (rsp_tready) rv_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (take && emit) begin
         rdata_ff <= rdata_in;
         ruser_ff <= ruser_in;
      end
   end

   assign rsp_tvalid = rv_ff;
   assign rsp_tdata  = rdata_ff;
   assign rsp_tuser  = ruser_ff;

endmodule

/* rtl/xild_checker.sv */
// ----------------------------------------------------------------------------
// xild_checker
// Port-level checks of the length decoder, bound to the top level.
// ----------------------------------------------------------------------------
`include "x86_instruction_length_decoder_core_macros.svh"
module xild_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_tvalid,
   input logic        req_tready,
   input logic        rsp_tvalid,
   input logic        rsp_tready,
   input logic [47:0] rsp_tdata,
   input logic [1:0]  rsp_tuser
);
   import xild_pkg::*;

   // A stalled result transaction keeps its payload.
   `XILD_ASSERT_NEXT(a_hold, clock, reset, rsp_tvalid && !rsp_tready, $stable(rsp_tdata) && $stable(rsp_tuser) && rsp_tvalid, "result changed while stalled")
   // Only ok results carry a length and a kind.
   `XILD_ASSERT_IMPLY(a_len, clock, reset, rsp_tvalid && rsp_tuser != ST_OK, rsp_tdata[39:32] == 8'd0, "failed result carries length")
   // Ok results are never empty.
   `XILD_ASSERT_IMPLY(a_nz, clock, reset, rsp_tvalid && rsp_tuser == ST_OK, rsp_tdata[37:32] != 6'd0, "ok result of zero length")
   // An offered byte is taken whenever the result register is free.
   `XILD_ASSERT_IMPLY(a_rdy, clock, reset, req_tvalid && !rsp_tvalid, req_tready, "input blocked with free output")

endmodule

bind x86_instruction_length_decoder_core xild_checker u_xild_checker (
   .clock(clock), .reset(reset), .req_tvalid(req_tvalid), .req_tready(req_tready),
   .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready), .rsp_tdata(rsp_tdata),
   .rsp_tuser(rsp_tuser)
);

/* tb/sv/testbench.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench
// Streams code bytes into the x86 length decoder and checks each boundary
// transaction against a behavioral length decoder kept in this file.
// ----------------------------------------------------------------------------
module testbench;
   import xild_pkg::*;

   localparam int MaxBytes = 32;
   localparam int CycleLimit = 400000;

   typedef struct packed {
      logic [31:0] start;
      logic [5:0]  length;
      logic [1:0]  kind;
      logic [4:0]  rep_off;
      logic [1:0]  status;
   } boundary_type;

   logic        clock;
   logic        reset;
   logic        req_tvalid;
   logic        req_tready;
   logic [7:0]  req_tdata;
   logic        req_tlast;
   logic        rsp_tvalid;
   logic        rsp_tready;
   logic [47:0] rsp_tdata;
   logic [1:0]  rsp_tuser;

   boundary_type expected_boundaries[$];
   int          mismatch_count = 0;
   int          cycle_count = 0;
   bit          quiet_mode;
   bit          hold_sink;
   int          hold_cycles;
   int          stall_left;

   // Decoder state of the predictor.
   phase_type   ph;
   int unsigned nbytes;
   logic        osz, rexw, rep_seen;
   logic [4:0]  rep_pos;
   logic [7:0]  op_held;
   logic [1:0]  op_map;
   logic [7:0]  modrm_q;
   logic [3:0]  trail_left;
   logic [2:0]  imm_pend;
   logic [1:0]  kind_q;
   logic [31:0] position;

   x86_instruction_length_decoder_core u_dut (
      .clock(clock), .reset(reset),
      .req_tvalid(req_tvalid), .req_tready(req_tready),
      .req_tdata(req_tdata), .req_tlast(req_tlast),
      .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready),
      .rsp_tdata(rsp_tdata), .rsp_tuser(rsp_tuser)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   function automatic logic legacy_prefix(input logic [7:0] b);
      return b == 8'h66 || b == 8'h67 || b == 8'hF0 || b == 8'hF2 || b == 8'hF3 ||
             b == 8'h2E || b == 8'h36 || b == 8'h3E || b == 8'h26 || b == 8'h64 ||
             b == 8'h65;
   endfunction

   function automatic logic modrm_one(input logic [7:0] op);
      if (op < 8'h40) return op[2] == 1'b0;
      if (op == 8'h63 || op == 8'h69 || op == 8'h6B) return 1'b1;
      if (op >= 8'h80 && op <= 8'h8F) return op != 8'h82;
      if (op == 8'hC0 || op == 8'hC1 || op == 8'hC6 || op == 8'hC7) return 1'b1;
      if (op >= 8'hD0 && op <= 8'hD3) return 1'b1;
      if (op >= 8'hD8 && op <= 8'hDF) return 1'b1;
      return op == 8'hF6 || op == 8'hF7 || op == 8'hFE || op == 8'hFF;
   endfunction

   function automatic logic [2:0] imm_one(input logic [7:0] op);
      if (op < 8'h40 && op[2:0] == 3'd4) return IMM_8;
      if (op < 8'h40 && op[2:0] == 3'd5) return IMM_Z;
      if (op == 8'h68 || op == 8'h69 || op == 8'h81 || op == 8'hA9 || op == 8'hC7 ||
          op == 8'hE8 || op == 8'hE9) return IMM_Z;
      if (op == 8'h6A || op == 8'h6B || op == 8'h80 || op == 8'h83 || op == 8'hA8)
         return IMM_8;
      if (op >= 8'h70 && op <= 8'h7F) return IMM_8;
      if (op >= 8'hA0 && op <= 8'hA3) return IMM_MOFF;
      if (op >= 8'hB0 && op <= 8'hB7) return IMM_8;
      if (op >= 8'hB8) begin
         if (op <= 8'hBF) return IMM_V;
      end
      if (op == 8'hC0 || op == 8'hC1 || op == 8'hC6 || op == 8'hCD || op == 8'hEB)
         return IMM_8;
      if (op == 8'hC2 || op == 8'hCA) return IMM_16;
      if (op == 8'hC8) return IMM_ENT;
      if (op >= 8'hE0 && op <= 8'hE7) return IMM_8;
      return IMM_NONE;
   endfunction

   function automatic logic modrm_0f(input logic [7:0] op);
      if ((op >= 8'h05 && op <= 8'h09) || op == 8'h0B || op == 8'h0E) return 1'b0;
      if ((op >= 8'h30 && op <= 8'h35) || op == 8'h37 || op == OP_VZERO) return 1'b0;
      if (op >= 8'h80 && op <= 8'h8F) return 1'b0;
      if (op == 8'hA0 || op == 8'hA1 || op == 8'hA2 || op == 8'hA8 || op == 8'hA9 ||
          op == 8'hAA) return 1'b0;
      if (op >= 8'hC8 && op <= 8'hCF) return 1'b0;
      return 1'b1;
   endfunction

   function automatic logic [2:0] imm_0f(input logic [7:0] op);
      if (op >= 8'h70 && op <= 8'h73) return IMM_8;
      if (op == 8'hA4 || op == 8'hAC || op == 8'hBA) return IMM_8;
      if (op == 8'hC2 || op == 8'hC4 || op == 8'hC5 || op == 8'hC6) return IMM_8;
      if (op >= 8'h80 && op <= 8'h8F) return IMM_Z;
      return IMM_NONE;
   endfunction

   function automatic int unsigned imm_bytes(input logic [2:0] code);
      case (code)
         IMM_8:    return 1;
         IMM_16:   return 2;
         IMM_Z:    return osz ? 2 : 4;
         IMM_V:    return rexw ? 8 : (osz ? 2 : 4);
         IMM_MOFF: return 8;
         IMM_ENT:  return 3;
         default:  return 0;
      endcase
   endfunction

   function automatic void clear_decode();
      ph = PH_PREFIX; nbytes = 0; osz = 0; rexw = 0; rep_seen = 0; rep_pos = 0;
      op_held = 0; op_map = 0; modrm_q = 0; trail_left = 0; imm_pend = 0; kind_q = 0;
   endfunction

   // Enters the trailing phase, or reports completion when nothing follows.
   function automatic logic tail_after(input int unsigned n);
      if (n == 0) return 1'b1;
      trail_left = n[3:0];
      ph = PH_TRAIL;
      return 1'b0;
   endfunction

   function automatic logic opcode_byte(input logic [7:0] b);
      op_held = b;
      if (b == OP_VEX2) begin
         op_map = 1; trail_left = 1; ph = PH_VEXHDR; return 1'b0;
      end
      if (b == OP_VEX3) begin
         op_map = 0; trail_left = 2; ph = PH_VEXHDR; return 1'b0;
      end
      if (b == OP_EVEX) begin
         op_map = 0; trail_left = 3; ph = PH_VEXHDR; return 1'b0;
      end
      if (b == OP_ESC) begin
         ph = PH_ESC0F; return 1'b0;
      end
      if (modrm_one(b)) begin
         imm_pend = (b == 8'hF6 || b == 8'hF7) ? IMM_GRP3 : imm_one(b);
         ph = PH_MODRM;
         return 1'b0;
      end
      return tail_after(imm_bytes(imm_one(b)));
   endfunction

   // Advances the decode by one byte; returns 1 when the instruction ends.
   function automatic logic decode_byte(input logic [7:0] b);
      logic [2:0] code;
      logic [1:0] md;
      int unsigned disp;
      case (ph)
         PH_PREFIX: begin
            if (legacy_prefix(b)) begin
               if (b == OP_OPSIZE) osz = 1;
               if (b == OP_REP) begin
                  rep_seen = 1;
                  rep_pos = (nbytes - 1 > 31) ? 5'd31 : 5'(nbytes - 1);
               end
               return 1'b0;
            end
            if (b[7:4] == 4'h4) begin
               rexw = b[3]; ph = PH_OPCODE; return 1'b0;
            end
            return opcode_byte(b);
         end
         PH_OPCODE: return opcode_byte(b);
         PH_VEXHDR: begin
            if (op_held == OP_VEX3 && trail_left == 2)
               op_map = (b[4:0] <= 3) ? b[1:0] : 2'd0;
            else if (op_held == OP_EVEX && trail_left == 3)
               op_map = b[1:0];
            trail_left = trail_left - 1;
            if (trail_left == 0) ph = PH_VEXOP;
            return 1'b0;
         end
         PH_VEXOP: begin
            code = (op_map == 3 || (op_map == 1 && imm_0f(b) == IMM_8)) ? IMM_8 : IMM_NONE;
            if (op_held != OP_EVEX && op_map == 1 && b == OP_VZERO) begin
               op_held = b;
               return tail_after(imm_bytes(code) == 0 ? 0 : 1);
            end
            op_held = b;
            imm_pend = code;
            ph = PH_MODRM;
            return 1'b0;
         end
         PH_ESC0F: begin
            op_held = b;
            if (b == OP_MAP38) begin
               imm_pend = IMM_NONE; ph = PH_OP3; return 1'b0;
            end
            if (b == OP_MAP3A) begin
               imm_pend = IMM_8; ph = PH_OP3; return 1'b0;
            end
            if (b == OP_ESC) begin
               imm_pend = IMM_8; ph = PH_MODRM; return 1'b0;
            end
            if (rep_seen && b == OP_LZCNT) kind_q = KIND_LZCNT;
            if (rep_seen && b == OP_TZCNT) kind_q = KIND_TZCNT;
            code = imm_0f(b);
            if (modrm_0f(b)) begin
               imm_pend = code; ph = PH_MODRM; return 1'b0;
            end
            return tail_after(imm_bytes(code));
         end
         PH_OP3: begin
            ph = PH_MODRM; return 1'b0;
         end
         PH_MODRM: begin
            modrm_q = b;
            code = imm_pend;
            if (code == IMM_GRP3) begin
               code = (b[5:3] < 2) ? ((op_held == 8'hF7) ? IMM_Z : IMM_8) : IMM_NONE;
               imm_pend = code;
            end
            md = b[7:6];
            if (md == 3) return tail_after(imm_bytes(code));
            if (b[2:0] == 4) begin
               ph = PH_SIB; return 1'b0;
            end
            disp = (md == 0 && b[2:0] == 5) ? 4 : (md == 1 ? 1 : (md == 2 ? 4 : 0));
            return tail_after(disp + imm_bytes(code));
         end
         PH_SIB: begin
            md = modrm_q[7:6];
            disp = (md == 0 && b[2:0] == 5) ? 4 : 0;
            disp += (md == 1) ? 1 : (md == 2 ? 4 : 0);
            return tail_after(disp + imm_bytes(imm_pend));
         end
         PH_TRAIL: begin
            trail_left = trail_left - 1;
            return trail_left == 0;
         end
         default: begin
            clear_decode();
            return 1'b0;
         end
      endcase
   endfunction

   // Predicts the boundary transaction, if any, caused by one accepted byte.
   task automatic predict_boundary(input logic [7:0] b, input logic last);
      boundary_type r;
      logic [31:0] start;
      start = position - nbytes;
      r = '0;
      r.start = start;
      if (nbytes + 1 > MaxBytes) begin
         r.status = ST_TOO_LONG;
         expected_boundaries.push_back(r);
         clear_decode();
      end else begin
         nbytes++;
         if (decode_byte(b)) begin
            r.length = 6'(nbytes);
            r.kind = kind_q;
            r.rep_off = (kind_q != KIND_NONE) ? rep_pos : 5'd0;
            r.status = ST_OK;
            expected_boundaries.push_back(r);
            clear_decode();
         end else if (last) begin
            r.status = ST_TRUNCATED;
            expected_boundaries.push_back(r);
            clear_decode();
         end
      end
      if (last) clear_decode();
      position = last ? 32'd0 : position + 1;
   endtask

   // Sends one code byte and waits for its acceptance.
   task automatic send_byte(input logic [7:0] b, input logic last = 1'b0);
      int gap;
      if (!quiet_mode && $urandom_range(0, 5) == 0) begin
         gap = $urandom_range(1, 4);
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata <= b;
      req_tlast <= last;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      predict_boundary(b, last);
   endtask

   task automatic send_list(input logic [7:0] bytes[$], input logic last = 1'b0);
      foreach (bytes[i]) send_byte(bytes[i], last && i == bytes.size() - 1);
   endtask

   task automatic go_idle();
      req_tvalid <= 1'b0;
      @(posedge clock);
   endtask

   // Receiver: short random stalls, the long hold on request, and field compare.
   always @(posedge clock) begin
      boundary_type got, want;
      if (reset) begin
         rsp_tready <= 1'b0;
         stall_left <= 0;
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            got = {rsp_tdata[31:0], rsp_tdata[37:32], rsp_tdata[39:38], rsp_tdata[44:40],
                   rsp_tuser};
            if (expected_boundaries.size() == 0) begin
               mismatch_count++;
               if (mismatch_count <= 10) $display("Unexpected boundary: exp none got %p",
                                                  got);
            end else begin
               want = expected_boundaries.pop_front();
               if (got !== want) begin
                  mismatch_count++;
                  if (mismatch_count <= 10) $display("Boundary mismatch: exp %p got %p",
                                                     want, got);
               end
            end
         end
         if (hold_sink && hold_cycles < 60) begin
            rsp_tready <= 1'b0;
         end else if (quiet_mode) begin
            rsp_tready <= 1'b1;
         end else if (!rsp_tready) begin
            if (stall_left == 0) rsp_tready <= 1'b1;
            else stall_left <= stall_left - 1;
         end else if ($urandom_range(0, 6) == 0) begin
            rsp_tready <= 1'b0;
            stall_left <= $urandom_range(0, 3);
         end
      end
   end

   // Length of the long receiver hold, in cycles.
   always @(posedge clock) begin
      if (reset) hold_cycles <= 0;
      else if (hold_sink && hold_cycles < 60) hold_cycles <= hold_cycles + 1;
   end

   // Watchdog.
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CycleLimit) begin
         $display("Verification failed");
         $finish;
      end
   end

   // Plain instruction shapes: prefixes, REX, maps, ModRM forms, immediates.
   task automatic test_directed_shapes();
      send_list('{8'h90});
      send_list('{8'h66, 8'h05, 8'h34, 8'h12});
      send_list('{8'h48, 8'hB8, 8'h00, 8'h11, 8'h22, 8'h33, 8'h44, 8'h55, 8'h66, 8'h77});
      send_list('{8'hF3, 8'h0F, 8'hBD, 8'hC1});
      send_list('{8'h66, 8'hF3, 8'hF3, 8'h0F, 8'hBC, 8'h04, 8'h25, 8'h00, 8'h00, 8'h00,
                  8'h00});
      send_list('{8'hF6, 8'h00, 8'h7F});
      send_list('{8'hF7, 8'hD8});
      send_list('{8'hC5, 8'hF8, 8'h77});
      send_list('{8'h62, 8'hF1, 8'h7C, 8'h48, 8'h77, 8'hC0});
      send_list('{8'hC4, 8'hE3, 8'h79, 8'h0F, 8'hC1, 8'h08});
      send_list('{8'h0F, 8'h0F, 8'hC1, 8'hB4});
      send_list('{8'h0F, 8'h38, 8'h00, 8'h44, 8'h24, 8'h10});
      send_list('{8'hC8, 8'h10, 8'h00, 8'h01});
      send_list('{8'hA1, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'hFF});
      send_list('{8'h40, 8'h66, 8'h0F, 8'h80, 8'h00, 8'h00, 8'h00, 8'h00});
   endtask

   // Truncation at region end, including inside prefixes.
   task automatic test_truncation();
      send_list('{8'h66, 8'hF3}, 1'b1);
      send_list('{8'h81, 8'h80, 8'h00}, 1'b1);
      send_list('{8'hC3}, 1'b1);
   endtask

   // Prefix runs up to and past the length bound, which also reach the largest rep offset.
   task automatic test_length_bound();
      repeat (40) send_byte(8'hF3);
      send_list('{8'h0F, 8'hBD, 8'hC0});
      repeat (31) send_byte(8'h66);
      send_byte(8'hF3, 1'b1);
      send_byte(8'hFF);
      send_byte(8'h00, 1'b1);
   endtask

   // Random instructions built from valid pieces, plus raw noise bytes.
   task automatic test_random_stream(input int count);
      logic [7:0] insn[$];
      int n, sent;
      sent = 0;
      while (sent < count) begin
         insn.delete();
         if ($urandom_range(0, 9) == 0) begin
            n = $urandom_range(1, 6);
            repeat (n) insn.push_back(8'($urandom));
         end else begin
            repeat ($urandom_range(0, 3)) begin
               case ($urandom_range(0, 4))
                  0: insn.push_back(OP_OPSIZE);
                  1: insn.push_back(OP_REP);
                  2: insn.push_back(8'hF2);
                  3: insn.push_back(8'h67);
                  default: insn.push_back(8'h2E);
               endcase
            end
            if ($urandom_range(0, 2) == 0) insn.push_back(8'h40 | 8'($urandom_range(0, 15)));
            case ($urandom_range(0, 5))
               0: insn.push_back(OP_ESC);
               1: begin
                  insn.push_back(OP_ESC);
                  insn.push_back($urandom_range(0, 1) ? OP_LZCNT : OP_TZCNT);
               end
               2: insn.push_back($urandom_range(0, 1) ? OP_VEX2 : OP_VEX3);
               3: insn.push_back(OP_EVEX);
               default: ;
            endcase
            repeat (12) insn.push_back(8'($urandom));
         end
         foreach (insn[i]) begin
            send_byte(insn[i], $urandom_range(0, 150) == 0);
            sent++;
         end
      end
   endtask

   initial begin
      reset = 1'b1;
      req_tvalid = 1'b0;
      req_tdata = 8'h00;
      req_tlast = 1'b0;
      quiet_mode = 1'b0;
      hold_sink = 1'b0;
      clear_decode();
      position = 0;
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_directed_shapes();
      test_truncation();
      test_length_bound();
      hold_sink = 1'b1;
      test_random_stream(150);
      test_random_stream(250);
      quiet_mode = 1'b1;
      test_random_stream(150);
      send_byte(8'hC3, 1'b1);
      go_idle();
      while (expected_boundaries.size() != 0) @(posedge clock);
      repeat (20) @(posedge clock);
      if (mismatch_count == 0 && expected_boundaries.size() == 0) begin
         $display("Verification passed");
      end else begin
         $display("Verification failed");
      end
      $finish;
   end

endmodule
